[src/apd_pkg.sv]
// ----------------------------------------------------------------------------
// Adaptive pulse detector package
// Shared sizes, register map, controller state type and command bundle.
// ----------------------------------------------------------------------------
package apd_pkg;

   // Noise history and energy sizes.
   localparam int HISTORY_LEN  = 10;
   localparam int ENERGY_WIDTH = 32;
   localparam int NUM_CH       = 3;
   localparam int SLOT_W       = $clog2(HISTORY_LEN);
   localparam int FILL_W       = $clog2(HISTORY_LEN + 1);
   localparam int SUM_W        = ENERGY_WIDTH + $clog2(HISTORY_LEN);

   // Configuration register widths and reset values.
   localparam int TF_W   = 8;
   localparam int MRUN_W = 4;
   localparam int PROD_W = SUM_W + TF_W;
   localparam logic [TF_W-1:0]   TF_RESET   = 8'd10;
   localparam logic [MRUN_W-1:0] MRUN_RESET = 4'd4;

   // Register map: index taken from the word address.
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_THRESHOLD = 1'b0;
   localparam logic REG_MIN_RUN   = 1'b1;

   // Flag record and onset run.
   localparam int FLAG_DEPTH = 11;
   localparam int FIDX_W     = $clog2(FLAG_DEPTH);
   localparam int FCNT_W     = $clog2(FLAG_DEPTH + 1);
   localparam int RUN_CAP    = 10;
   localparam int RUN_W      = 4;

   // Stream widths.
   localparam int REQ_DATA_W = NUM_CH * ENERGY_WIDTH;
   localparam int RSP_DATA_W = 8;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_MUL,
      S_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic read;
      logic mul;
      logic commit;
   } cmd_type;

endpackage

[src/apd_csr.sv]
// ----------------------------------------------------------------------------
// Adaptive pulse detector register file
// APB-style access to the threshold factor and the minimum run length.
// ----------------------------------------------------------------------------
module apd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [apd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready,
   output logic [apd_pkg::TF_W-1:0]          threshold_factor,
   output logic [apd_pkg::MRUN_W-1:0]        min_run_bins
);

   logic [apd_pkg::TF_W-1:0]   tf_ff, tf_in;
   logic [apd_pkg::MRUN_W-1:0] mrun_ff, mrun_in;
   logic                       wr_en;
   logic                       reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[2];

   // Next values of the registers on a write transaction.
   always_comb begin
      tf_in   = tf_ff;
      mrun_in = mrun_ff;
      if (wr_en) begin
         case (reg_idx)
            apd_pkg::REG_THRESHOLD: tf_in   = csr_pwdata[apd_pkg::TF_W-1:0];
            apd_pkg::REG_MIN_RUN:   mrun_in = csr_pwdata[apd_pkg::MRUN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tf_ff   <= apd_pkg::TF_RESET;
         mrun_ff <= apd_pkg::MRUN_RESET;
      end else begin
         tf_ff   <= tf_in;
         mrun_ff <= mrun_in;
      end
   end

   // Read data.
   always_comb begin
      case (reg_idx)
         apd_pkg::REG_THRESHOLD: csr_prdata = 32'(tf_ff);
         apd_pkg::REG_MIN_RUN:   csr_prdata = 32'(mrun_ff);
         default:                csr_prdata = '0;
      endcase
   end

   assign threshold_factor = tf_ff;
   assign min_run_bins     = mrun_ff;

endmodule

[src/apd_ctrl.sv]
// ----------------------------------------------------------------------------
// Adaptive pulse detector controller
// Sequences capture, history read, multiply and commit for one transaction
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module apd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output apd_pkg::cmd_type  cmd
);

   apd_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   // The output register can take a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         apd_pkg::S_IDLE: if (req_tvalid) state_in = apd_pkg::S_READ;
         apd_pkg::S_READ: state_in = apd_pkg::S_MUL;
         apd_pkg::S_MUL:  state_in = apd_pkg::S_DONE;
         apd_pkg::S_DONE: if (out_free) state_in = apd_pkg::S_IDLE;
         default:         state_in = apd_pkg::S_IDLE;
      endcase
   end

   // Outputs per state.
   always_comb begin
      req_tready  = 1'b0;
      cmd         = '0;
      case (state_ff)
         apd_pkg::S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         apd_pkg::S_READ: cmd.read   = 1'b1;
         apd_pkg::S_MUL:  cmd.mul    = 1'b1;
         apd_pkg::S_DONE: cmd.commit = out_free;
         default: ;
      endcase
   end

   // Result valid: set on commit, cleared when the consumer takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= apd_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // A commit never overwrites a result that is still waiting.
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("commit while result pending");

   // An accepted transaction goes straight to the history read.
   a_accept_read: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == apd_pkg::S_READ))
      else $error("accept not followed by read");

   // A commit always produces a valid result in the next cycle.
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit lost");

endmodule

[src/apd_dp.sv]
// ----------------------------------------------------------------------------
// Adaptive pulse detector datapath
// Noise history memory with running sums, threshold multiply and compare,
// flag record and onset run measurement, and the result register.
// ----------------------------------------------------------------------------
module apd_dp (
   input  logic                                     clock,
   input  logic                                     reset,
   input  apd_pkg::cmd_type                         cmd,
   input  logic [apd_pkg::REQ_DATA_W-1:0]           energy_in,
   input  logic [apd_pkg::TF_W-1:0]                 threshold_factor,
   input  logic [apd_pkg::MRUN_W-1:0]               min_run_bins,
   output logic                                     warming,
   output logic                                     window_flag,
   output logic                                     onset_seen,
   output logic                                     pulse_qualified,
   output logic [apd_pkg::RUN_W-1:0]                run_length
);

   // Captured energies, history read data, running sums and products.
   logic [apd_pkg::ENERGY_WIDTH-1:0] energy_ff [apd_pkg::NUM_CH];
   logic [apd_pkg::ENERGY_WIDTH-1:0] old_val   [apd_pkg::NUM_CH];
   logic [apd_pkg::SUM_W-1:0]        sum_ff    [apd_pkg::NUM_CH];
   logic [apd_pkg::SUM_W-1:0]        sum_in    [apd_pkg::NUM_CH];
   logic [apd_pkg::SUM_W-1:0]        scaled_ff [apd_pkg::NUM_CH];
   logic [apd_pkg::PROD_W-1:0]       thr_ff    [apd_pkg::NUM_CH];
   logic [apd_pkg::REQ_DATA_W-1:0]   hist_mem  [apd_pkg::HISTORY_LEN];
   logic [apd_pkg::REQ_DATA_W-1:0]   hist_rd_ff;

   // Control state of the history and flag record.
   logic [apd_pkg::SLOT_W-1:0]       slot_ff, slot_in;
   logic [apd_pkg::FILL_W-1:0]       fill_ff, fill_in;
   logic [apd_pkg::FLAG_DEPTH-1:0]   rec_ff, rec_in, rec_new;
   logic [apd_pkg::FCNT_W-1:0]       cnt_ff, cnt_in, cnt_new;

   // Result register.
   logic                             warm_out_ff, warm_out_in;
   logic                             flag_out_ff, flag_out_in;
   logic                             onset_out_ff, onset_out_in;
   logic                             qual_out_ff, qual_out_in;
   logic [apd_pkg::RUN_W-1:0]        run_out_ff, run_out_in;

   logic                             warm;
   logic                             flag;
   logic                             hist_we;
   logic [apd_pkg::NUM_CH-1:0]       above;
   logic                             onset;
   logic [apd_pkg::RUN_W-1:0]        run;
   logic                             stop;

   // Energy capture at the accepted transaction.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         for (int ch = 0; ch < apd_pkg::NUM_CH; ch++) begin
            energy_ff[ch] <= energy_in[ch*apd_pkg::ENERGY_WIDTH +: apd_pkg::ENERGY_WIDTH];
         end
      end
   end

   // History memory: read the entry about to be replaced, write on a commit of an unflagged window.
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         hist_rd_ff <= hist_mem[slot_ff];
      end
      if (cmd.commit && hist_we) begin
         hist_mem[slot_ff] <= {energy_ff[2], energy_ff[1], energy_ff[0]};
      end
   end

   always_comb begin
      for (int ch = 0; ch < apd_pkg::NUM_CH; ch++) begin
         old_val[ch] = hist_rd_ff[ch*apd_pkg::ENERGY_WIDTH +: apd_pkg::ENERGY_WIDTH];
      end
   end

   // Multiply stage: threshold times history sum, energy times history length.
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         for (int ch = 0; ch < apd_pkg::NUM_CH; ch++) begin
            thr_ff[ch]    <= apd_pkg::PROD_W'(threshold_factor) *
                             apd_pkg::PROD_W'(sum_ff[ch]);
            scaled_ff[ch] <= apd_pkg::SUM_W'(energy_ff[ch]) *
                             apd_pkg::SUM_W'(apd_pkg::HISTORY_LEN);
         end
      end
   end

   // Window decision.
   assign warm = (fill_ff < apd_pkg::FILL_W'(apd_pkg::HISTORY_LEN));
   always_comb begin
      for (int ch = 0; ch < apd_pkg::NUM_CH; ch++) begin
         above[ch] = apd_pkg::PROD_W'(scaled_ff[ch]) > thr_ff[ch];
      end
   end
   assign flag    = !warm && (&above);
   assign hist_we = warm || !flag;

   // Running sums: during warm-up the slot was never written, so only add.
   always_comb begin
      for (int ch = 0; ch < apd_pkg::NUM_CH; ch++) begin
         if (warm) begin
            sum_in[ch] = sum_ff[ch] + apd_pkg::SUM_W'(energy_ff[ch]);
         end else begin
            sum_in[ch] = sum_ff[ch] - apd_pkg::SUM_W'(old_val[ch]) +
                         apd_pkg::SUM_W'(energy_ff[ch]);
         end
      end
   end

   // Rotating slot and fill count.
   always_comb begin
      slot_in = slot_ff;
      fill_in = fill_ff;
      if (hist_we) begin
         if (slot_ff == apd_pkg::SLOT_W'(apd_pkg::HISTORY_LEN - 1)) begin
            slot_in = '0;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
      if (warm) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   // Flag record: append the new flag, then look for an onset.
   always_comb begin
      rec_new = rec_ff;
      rec_new[cnt_ff[apd_pkg::FIDX_W-1:0]] = flag;
      cnt_new = cnt_ff + 1'b1;
   end

   // Run of set flags from the second-oldest one; unrecorded flags stop it.
   always_comb begin
      run  = '0;
      stop = 1'b0;
      for (int i = 1; i <= apd_pkg::RUN_CAP; i++) begin
         if (!stop && rec_new[i] && (apd_pkg::FCNT_W'(i) < cnt_new)) begin
            run = run + 1'b1;
         end else begin
            stop = 1'b1;
         end
      end
   end

   assign onset = (cnt_new >= apd_pkg::FCNT_W'(2)) && !rec_new[0] && rec_new[1];

   // Record aging and result fields.
   always_comb begin
      rec_in       = rec_ff;
      cnt_in       = cnt_ff;
      warm_out_in  = 1'b1;
      flag_out_in  = 1'b0;
      onset_out_in = 1'b0;
      qual_out_in  = 1'b0;
      run_out_in   = '0;
      if (!warm) begin
         if (cnt_new > apd_pkg::FCNT_W'(apd_pkg::FLAG_DEPTH - 1)) begin
            rec_in = rec_new >> 1;
            cnt_in = cnt_new - 1'b1;
         end else begin
            rec_in = rec_new;
            cnt_in = cnt_new;
         end
         warm_out_in  = 1'b0;
         flag_out_in  = flag;
         onset_out_in = onset;
         if (onset) begin
            run_out_in  = run;
            qual_out_in = (run >= min_run_bins);
         end
      end
   end

   // Control state of the datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= apd_pkg::SLOT_W'(1);
         fill_ff <= '0;
         rec_ff  <= '0;
         cnt_ff  <= '0;
         for (int ch = 0; ch < apd_pkg::NUM_CH; ch++) begin
            sum_ff[ch] <= '0;
         end
      end else if (cmd.commit) begin
         slot_ff <= slot_in;
         fill_ff <= fill_in;
         rec_ff  <= rec_in;
         cnt_ff  <= cnt_in;
         if (hist_we) begin
            for (int ch = 0; ch < apd_pkg::NUM_CH; ch++) begin
               sum_ff[ch] <= sum_in[ch];
            end
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         warm_out_ff  <= warm_out_in;
         flag_out_ff  <= flag_out_in;
         onset_out_ff <= onset_out_in;
         qual_out_ff  <= qual_out_in;
         run_out_ff   <= run_out_in;
      end
   end

   assign warming         = warm_out_ff;
   assign window_flag     = flag_out_ff;
   assign onset_seen      = onset_out_ff;
   assign pulse_qualified = qual_out_ff;
   assign run_length      = run_out_ff;

   // The flag record never holds more than ten flags between windows.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= apd_pkg::FCNT_W'(apd_pkg::FLAG_DEPTH - 1))
      else $error("flag record overfull");

   // Flags are recorded only once the history is full.
   a_no_flag_warm: assert property (@(posedge clock) disable iff (reset)
      warm |-> (cnt_ff == '0))
      else $error("flag recorded during warm-up");

   // A flagged window leaves the slot and the sums alone.
   a_flag_freeze: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && flag) |=> $stable(slot_ff))
      else $error("history moved on flagged window");

   // A qualified pulse always comes with an onset and a nonzero run.
   a_qual_onset: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && qual_out_in) |-> (onset && (run != '0)))
      else $error("qualified without onset");

endmodule

[src/adaptive_pulse_detector_unit.sv]
// ----------------------------------------------------------------------------
// Adaptive pulse detector unit
// Three-channel cell-averaging detector over a ten-window noise history,
// followed by a pulse onset and run-length check on the window flags.
//
// Channel  | Direction | Transaction carries
// ---------+-----------+----------------------------------------------------
// req_     | in        | energies of channels one, two and three
// rsp_     | out       | warming, window flag, onset, qualified, run length
// csr_     | in/out    | threshold factor (0x0), minimum run length (0x4)
//
// When results are taken promptly, an item passes through accept, history
// read, multiply and commit; the history memory read and the registered
// multiply account for the middle two steps. One item is in flight at a time.
// Reset is synchronous; it clears control state and needs no clearing pass.
// A stalled result holds in the output register; the next item is accepted
// and worked on, and waits at commit until the output register is free.
// ----------------------------------------------------------------------------
module adaptive_pulse_detector_unit (
   input  logic                                clock,
   input  logic                                reset,
   // Input stream; tdata: energy_a [31:0], energy_b [63:32], energy_c [95:64].
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [apd_pkg::REQ_DATA_W-1:0]      req_tdata,
   // Result stream; tdata: warming [0], window_flag [1], onset_seen [2],
   // pulse_qualified [3], run_length [7:4].
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [apd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // Configuration port.
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [apd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   apd_pkg::cmd_type              cmd;
   logic [apd_pkg::TF_W-1:0]      threshold_factor;
   logic [apd_pkg::MRUN_W-1:0]    min_run_bins;
   logic                          warming;
   logic                          window_flag;
   logic                          onset_seen;
   logic                          pulse_qualified;
   logic [apd_pkg::RUN_W-1:0]     run_length;

   // Configuration registers.
   apd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .threshold_factor (threshold_factor),
      .min_run_bins     (min_run_bins)
   );

   // Sequencer.
   apd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Datapath.
   apd_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .energy_in        (req_tdata),
      .threshold_factor (threshold_factor),
      .min_run_bins     (min_run_bins),
      .warming          (warming),
      .window_flag      (window_flag),
      .onset_seen       (onset_seen),
      .pulse_qualified  (pulse_qualified),
      .run_length       (run_length)
   );

   // Pack the result fields, lowest bit first.
   assign rsp_tdata = {run_length, pulse_qualified, onset_seen, window_flag, warming};

endmodule
